### rtl/ads_pkg.sv
// Shared types and constants for the ascending/descending sorter.
// Used by the channel interfaces, the cell chain and the top level; depends on nothing else.
package ads_pkg;

    localparam int MAX_ELEMS = 64;
    localparam int DATA_W    = 32;
    localparam int CNT_W     = $clog2(MAX_ELEMS + 1);

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic [CNT_W-1:0]         t_count;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT_DOWN,
        CELL_SHIFT_UP
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        t_data    din;
    } t_cell_ctrl;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } t_state;

endpackage

### rtl/ads_ifs.sv
// Valid/ready channel interfaces of the sorter: input set, sorted results
// and the direction register write port. Depends on ads_pkg.
interface ads_in_if import ads_pkg::*;;
    logic  valid;
    logic  ready;
    t_data value;
    logic  is_last;

    modport source (output valid, output value, output is_last, input ready);
    modport sink   (input valid, input value, input is_last, output ready);
endinterface

interface ads_out_if import ads_pkg::*;;
    logic  valid;
    logic  ready;
    t_data sorted_value;
    logic  last_out;
    logic  overflowed;

    modport source (output valid, output sorted_value, output last_out,
                    output overflowed, input ready);
    modport sink   (input valid, input sorted_value, input last_out,
                    input overflowed, output ready);
endinterface

interface ads_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/ads_cell.sv
// One cell of the sorting chain: holds one value and its valid bit.
// Depends on ads_pkg for the data type and the cell control struct.
module ads_cell import ads_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  t_data      i_prev_val,
    input  logic       i_prev_vld,
    input  logic       i_prev_ins,
    input  t_data      i_next_val,
    input  logic       i_next_vld,
    output t_data      o_val,
    output logic       o_vld,
    output logic       o_ins
);

    t_data r_val, n_val;
    logic  r_vld, n_vld;

    // The broadcast value goes in front of this cell's value if smaller. An
    // empty cell counts as larger than anything, so the chain stays ascending.
    assign o_ins = !r_vld || (i_ctrl.din < r_val);

    always_comb begin
        n_val = r_val;
        n_vld = r_vld;
        case (i_ctrl.op)
            CELL_INSERT: begin
                if (o_ins) begin
                    n_val = i_prev_ins ? i_prev_val : i_ctrl.din;
                    n_vld = i_prev_ins ? i_prev_vld : 1'b1;
                end
            end
            CELL_SHIFT_DOWN: begin
                n_val = i_next_val;
                n_vld = i_next_vld;
            end
            CELL_SHIFT_UP: begin
                n_val = i_prev_val;
                n_vld = i_prev_vld;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;
    assign o_vld = r_vld;

endmodule

### rtl/ascending_descending_sorter_top.sv
// Top level of the sorter: load/emit controller, cell chain and output register.
// Depends on ads_pkg, the channel interfaces in ads_ifs and ads_cell.
//
// Usage: values arrive on i_in, one per beat, the final value of a set marked
// by is_last. Every beat is accepted while loading and inserted into a row of
// MAX_ELEMS cells that keeps the set in ascending order at all times. Beats
// beyond capacity are dropped and the set's results carry overflowed = 1.
// After the is_last beat the block stops taking input and emits the set on
// o_out, one result per cycle while the receiver is ready, last_out marking the
// final one. Ascending order shifts the chain toward its first cell; descending
// order shifts it toward the far end, so for n values the first result waits
// for MAX_ELEMS - n bubble shifts. The is_last beat moves the controller to
// ST_EMIT, which loads the first result into the output register, after the
// bubble shifts in descending order. A stalled receiver freezes the chain; the
// output register holds its beat until taken. The next set is accepted once
// the final result sits in the output register. i_cfg writes the direction bit
// (1 = descending) and is always ready. Reset empties the chain, clears the
// count and overflow flag and selects ascending order; no clearing pass.
module ascending_descending_sorter_top import ads_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ads_in_if.sink    i_in,
    ads_out_if.source o_out,
    ads_cfg_if.sink   i_cfg
);

    t_state     r_state, n_state;
    t_count     r_count, n_count;
    t_count     r_remain, n_remain;
    logic       r_ovf, n_ovf;
    logic       r_desc;
    logic       r_out_vld, n_out_vld;
    t_data      r_out_val, n_out_val;
    logic       r_out_last, n_out_last;
    logic       r_out_ovf, n_out_ovf;
    t_cell_ctrl w_ctrl;

    t_data                w_val [MAX_ELEMS];
    logic [MAX_ELEMS-1:0] w_vld;
    logic [MAX_ELEMS-1:0] w_ins;

    logic w_full;
    logic w_in_beat;
    logic w_advance;

    assign w_full    = (r_count == t_count'(MAX_ELEMS));
    assign w_in_beat = i_in.valid && i_in.ready;
    assign w_advance = !r_out_vld || o_out.ready;

    assign i_in.ready  = (r_state == ST_LOAD);
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_desc <= 1'b0;
        end else if (i_cfg.valid) begin
            r_desc <= i_cfg.data;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ELEMS; gi++) begin : g_cell
            t_data w_prev_val, w_next_val;
            logic  w_prev_vld, w_prev_ins, w_next_vld;
            if (gi == 0) begin : g_first
                assign w_prev_val = w_ctrl.din;
                assign w_prev_vld = (w_ctrl.op == CELL_INSERT);
                assign w_prev_ins = 1'b0;
            end else begin : g_mid
                assign w_prev_val = w_val[gi-1];
                assign w_prev_vld = w_vld[gi-1];
                assign w_prev_ins = w_ins[gi-1];
            end
            if (gi == MAX_ELEMS - 1) begin : g_last
                assign w_next_val = w_val[gi];
                assign w_next_vld = 1'b0;
            end else begin : g_inner
                assign w_next_val = w_val[gi+1];
                assign w_next_vld = w_vld[gi+1];
            end
            ads_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctrl     (w_ctrl),
                .i_prev_val (w_prev_val),
                .i_prev_vld (w_prev_vld),
                .i_prev_ins (w_prev_ins),
                .i_next_val (w_next_val),
                .i_next_vld (w_next_vld),
                .o_val      (w_val[gi]),
                .o_vld      (w_vld[gi]),
                .o_ins      (w_ins[gi])
            );
        end
    endgenerate

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_remain   = r_remain;
        n_ovf      = r_ovf;
        w_ctrl.op  = CELL_HOLD;
        w_ctrl.din = i_in.value;
        n_out_vld  = r_out_vld && !o_out.ready;
        n_out_val  = r_out_val;
        n_out_last = r_out_last;
        n_out_ovf  = r_out_ovf;
        case (r_state)
            ST_LOAD: begin
                if (w_in_beat) begin
                    if (w_full) begin
                        n_ovf = 1'b1;
                    end else begin
                        w_ctrl.op = CELL_INSERT;
                        n_count   = r_count + t_count'(1);
                    end
                    if (i_in.is_last) begin
                        n_remain = n_count;
                        n_state  = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (w_advance) begin
                    if (!r_desc) begin
                        w_ctrl.op = CELL_SHIFT_DOWN;
                        n_out_val = w_val[0];
                    end else begin
                        w_ctrl.op = CELL_SHIFT_UP;
                        n_out_val = w_val[MAX_ELEMS-1];
                    end
                    // Descending runs push empty cells out of the far end first.
                    if (!r_desc || w_vld[MAX_ELEMS-1]) begin
                        n_out_vld  = 1'b1;
                        n_out_last = (r_remain == t_count'(1));
                        n_out_ovf  = r_ovf;
                        n_remain   = r_remain - t_count'(1);
                        if (r_remain == t_count'(1)) begin
                            n_state = ST_LOAD;
                            n_count = '0;
                            n_ovf   = 1'b0;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_count   <= '0;
            r_remain  <= '0;
            r_ovf     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_remain  <= n_remain;
            r_ovf     <= n_ovf;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_val  <= n_out_val;
        r_out_last <= n_out_last;
        r_out_ovf  <= n_out_ovf;
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.sorted_value = r_out_val;
    assign o_out.last_out     = r_out_last;
    assign o_out.overflowed   = r_out_ovf;

    // While loading, the occupied cells match the element count.
    a_count_matches_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD) |-> ($countones(w_vld) == int'(r_count)))
        else $error("cell occupancy differs from element count");

    // The count never exceeds capacity.
    a_count_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_count'(MAX_ELEMS))
        else $error("element count beyond capacity");

    // A stalled output beat is not overwritten by the chain.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !o_out.ready) |=> (r_out_vld && $stable(r_out_val)))
        else $error("stalled result changed");

    // A non-empty set enters emission with at least one result pending.
    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_beat && i_in.is_last) |=> (r_state == ST_EMIT && r_remain != '0))
        else $error("emission started with nothing to send");

endmodule
